// File: rtl/wspl_pkg.sv
// Shared types, constants and the control store for the wheel speed PI loop.
// No dependencies; every other file of the block imports this package.
package wspl_pkg;

    localparam int SCALE_FRAC_BITS = 8;

    localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [2:0] REG_INTEG_UPPER  = 3'd2;
    localparam logic [2:0] REG_INTEG_LOWER  = 3'd3;
    localparam logic [2:0] REG_SPEED_SCALE  = 3'd4;
    localparam logic [2:0] REG_COUNT_NEGATE = 3'd5;
    localparam logic [2:0] REG_DUTY_LIMIT   = 3'd6;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    typedef logic [3:0] step_t;

    localparam step_t STEP_EDGE     = 4'd0;
    localparam step_t STEP_MUL_SPD  = 4'd1;
    localparam step_t STEP_SHIFT    = 4'd2;
    localparam step_t STEP_SPEED    = 4'd3;
    localparam step_t STEP_ERR      = 4'd4;
    localparam step_t STEP_SUM      = 4'd5;
    localparam step_t STEP_MUL_INT  = 4'd6;
    localparam step_t STEP_ADD      = 4'd7;
    localparam step_t STEP_TRUNC    = 4'd8;
    localparam step_t STEP_EMIT     = 4'd9;
    localparam step_t STEP_STOP     = 4'd10;

    typedef enum logic [1:0] {
        MUL_SPEED,
        MUL_PROP,
        MUL_INTEG
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_SPD,
        ACC_LOAD_PROD,
        ACC_ADD_PROD,
        ACC_TRUNC_OUT
    } acc_op_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_RUN,
        EMIT_STOP
    } emit_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_JZ,
        SEQ_DONE
    } seq_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     prod_en;
        acc_op_t  acc_op;
        logic     speed_en;
        logic     err_en;
        logic     sum_en;
        logic     edge_en;
        emit_t    emit;
        seq_t     seq;
        step_t    target;
    } ctrl_word_t;

    typedef struct packed {
        logic target_zero;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [15:0]        prop_gain;
        logic [15:0]        integ_gain;
        logic [14:0]        integ_upper;
        logic signed [15:0] integ_lower;
        logic [15:0]        speed_scale;
        logic               count_negate;
        logic [15:0]        duty_limit;
    } cfg_t;

    localparam ctrl_word_t UCODE_NOP = '{
        mul_sel:  MUL_SPEED,
        prod_en:  1'b0,
        acc_op:   ACC_HOLD,
        speed_en: 1'b0,
        err_en:   1'b0,
        sum_en:   1'b0,
        edge_en:  1'b0,
        emit:     EMIT_NONE,
        seq:      SEQ_NEXT,
        target:   STEP_EDGE
    };

    function automatic ctrl_word_t ucode_rom(input step_t addr);
        ctrl_word_t w;
        w = UCODE_NOP;
        unique case (addr)
            STEP_EDGE:
            begin
                w.edge_en = 1'b1;
                w.seq     = SEQ_DONE;
            end
            STEP_MUL_SPD:
            begin
                w.mul_sel = MUL_SPEED;
                w.prod_en = 1'b1;
            end
            STEP_SHIFT:
            begin
                w.acc_op = ACC_LOAD_SPD;
            end
            STEP_SPEED:
            begin
                w.speed_en = 1'b1;
                w.seq      = SEQ_JZ;
                w.target   = STEP_STOP;
            end
            STEP_ERR:
            begin
                w.err_en = 1'b1;
            end
            STEP_SUM:
            begin
                w.sum_en  = 1'b1;
                w.mul_sel = MUL_PROP;
                w.prod_en = 1'b1;
            end
            STEP_MUL_INT:
            begin
                w.mul_sel = MUL_INTEG;
                w.prod_en = 1'b1;
                w.acc_op  = ACC_LOAD_PROD;
            end
            STEP_ADD:
            begin
                w.acc_op = ACC_ADD_PROD;
            end
            STEP_TRUNC:
            begin
                w.acc_op = ACC_TRUNC_OUT;
            end
            STEP_EMIT:
            begin
                w.emit = EMIT_RUN;
                w.seq  = SEQ_DONE;
            end
            STEP_STOP:
            begin
                w.emit = EMIT_STOP;
                w.seq  = SEQ_DONE;
            end
            default:
            begin
                w.seq = SEQ_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/wheel_speed_pi_loop.sv
// Top level of the wheel speed PI loop: configuration registers, sequencer and datapath.
// Depends on wspl_pkg, wspl_useq and wspl_dpath.
//
// Usage. Items enter on the item channel (item_valid, item_stall): op 0 is an
// encoder edge that steps the saturating pulse counter, op 1 is a sample tick
// that measures speed, runs the PI law and produces one result beat.
// Results leave on the result channel (result_valid, result_stall) with the
// direction, the duty value and the measured speed of that sample.
// Configuration is written through cfg_valid, cfg_ready, cfg_index and
// cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce; cfg_ready is always high.
// An edge item runs only the EDGE step of the microprogram. A tick runs
// MUL_SPD, SHIFT, SPEED, ERR, SUM, MUL_INT, ADD, TRUNC and EMIT in order and
// registers its result at EMIT; with a zero target it jumps from SPEED to STOP.
// The next item is taken once the microprogram is done, in which one shared
// multiplier serves the speed, proportional and integral products in turn.
// Reset clears the counter, the integral and the result valid flag and loads
// the default gains and limits.
// While the receiver stalls, a held result stays in the output register; a
// further tick waits at its final step until that beat is taken.
module wheel_speed_pi_loop
    import wspl_pkg::*;
#(
    parameter int COUNT_WIDTH     = 16,
    parameter int SPEED_FRAC_BITS = 4,
    parameter int GAIN_FRAC_BITS  = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               op,
    input  logic               phase_b,
    input  logic signed [15:0] setpoint,
    input  logic               restart,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         drive_dir,
    output logic [15:0]        duty,
    output logic signed [15:0] measured_speed,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    ctrl_word_t ctrl;
    dp_status_t status;
    logic       busy;
    logic       accept;

    assign cfg_ready  = 1'b1;
    assign item_stall = busy;
    assign accept     = item_valid && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:    cfg_next.prop_gain    = cfg_data;
                REG_INTEG_GAIN:   cfg_next.integ_gain   = cfg_data;
                REG_INTEG_UPPER:  cfg_next.integ_upper  = cfg_data[14:0];
                REG_INTEG_LOWER:  cfg_next.integ_lower  = $signed(cfg_data);
                REG_SPEED_SCALE:  cfg_next.speed_scale  = cfg_data;
                REG_COUNT_NEGATE: cfg_next.count_negate = cfg_data[0];
                REG_DUTY_LIMIT:   cfg_next.duty_limit   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain    <= 16'd1280;
            cfg_reg.integ_gain   <= 16'd461;
            cfg_reg.integ_upper  <= 15'd32000;
            cfg_reg.integ_lower  <= -16'sd32000;
            cfg_reg.speed_scale  <= 16'd2872;
            cfg_reg.count_negate <= 1'b0;
            cfg_reg.duty_limit   <= 16'd4000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wspl_useq u_useq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .start_tick (op),
        .status     (status),
        .ctrl       (ctrl),
        .busy       (busy)
    );

    wspl_dpath #(
        .COUNT_WIDTH     (COUNT_WIDTH),
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
        .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg            (cfg_reg),
        .accept         (accept),
        .phase_b        (phase_b),
        .setpoint       (setpoint),
        .restart        (restart),
        .status         (status),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .drive_dir      (drive_dir),
        .duty           (duty),
        .measured_speed (measured_speed)
    );

endmodule

// File: rtl/wspl_useq.sv
// Microcode sequencer: step counter, control store read and conditional jumps.
// Depends on wspl_pkg for the control word, the status struct and the control store.
module wspl_useq
    import wspl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       start_tick,
    input  dp_status_t status,
    output ctrl_word_t ctrl,
    output logic       busy
);

    logic       busy_reg;
    logic       busy_next;
    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t word;
    logic       advance;

    always_comb
    begin
        word      = ucode_rom(step_reg);
        ctrl      = busy_reg ? word : UCODE_NOP;
        advance   = (word.emit == EMIT_NONE) || status.out_free;
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = start_tick ? STEP_MUL_SPD : STEP_EDGE;
            end
        end
        else if (advance)
        begin
            unique case (word.seq)
                SEQ_NEXT: step_next = step_reg + 4'd1;
                SEQ_JZ:   step_next = status.target_zero ? word.target : step_reg + 4'd1;
                SEQ_DONE: busy_next = 1'b0;
                default:  busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_EDGE;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign busy = busy_reg;

endmodule

// File: rtl/wspl_dpath.sv
// Datapath: pulse counter, shared multiplier, accumulator, PI state and result register.
// Depends on wspl_pkg; driven one control word per cycle by wspl_useq.
module wspl_dpath
    import wspl_pkg::*;
#(
    parameter int COUNT_WIDTH     = 16,
    parameter int SPEED_FRAC_BITS = 4,
    parameter int GAIN_FRAC_BITS  = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_word_t         ctrl,
    input  cfg_t               cfg,
    input  logic               accept,
    input  logic               phase_b,
    input  logic signed [15:0] setpoint,
    input  logic               restart,
    output dp_status_t         status,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         drive_dir,
    output logic [15:0]        duty,
    output logic signed [15:0] measured_speed
);

    localparam int AW     = (COUNT_WIDTH > 17) ? COUNT_WIDTH : 17;
    localparam int PRW    = AW + 17;
    localparam int SPD_SH = SCALE_FRAC_BITS - SPEED_FRAC_BITS;
    localparam int OUT_SH = GAIN_FRAC_BITS + SPEED_FRAC_BITS;

    localparam logic signed [PRW-1:0] SPD_BIAS = PRW'((64'd1 << SPD_SH) - 64'd1);
    localparam logic signed [PRW-1:0] OUT_BIAS = PRW'((64'd1 << OUT_SH) - 64'd1);
    localparam logic signed [PRW-1:0] SPD_MAX  = PRW'(32767);
    localparam logic signed [PRW-1:0] SPD_MIN  = -PRW'(32768);
    localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    logic signed [COUNT_WIDTH-1:0] count_reg;
    logic signed [COUNT_WIDTH-1:0] count_next;
    logic signed [15:0]            integ_reg;
    logic signed [15:0]            integ_next;
    logic                          result_valid_reg;
    logic                          result_valid_next;

    logic                          phase_b_reg;
    logic signed [15:0]            target_reg;
    logic                          restart_reg;
    logic signed [PRW-1:0]         prod_reg;
    logic signed [PRW-1:0]         prod_next;
    logic signed [PRW-1:0]         acc_reg;
    logic signed [PRW-1:0]         acc_next;
    logic signed [15:0]            speed_reg;
    logic signed [15:0]            speed_next;
    logic signed [16:0]            err_reg;
    logic signed [16:0]            err_next;
    logic [1:0]                    dir_reg;
    logic [1:0]                    dir_next;
    logic [15:0]                   duty_reg;
    logic [15:0]                   duty_next;
    logic signed [15:0]            mspeed_reg;
    logic signed [15:0]            mspeed_next;

    logic signed [AW-1:0]          mul_a;
    logic signed [16:0]            mul_b;
    logic signed [PRW-1:0]         spd_round;
    logic signed [PRW-1:0]         out_round;
    logic signed [PRW-1:0]         spd_val;
    logic signed [17:0]            sum_raw;
    logic signed [17:0]            upper_ext;
    logic signed [17:0]            lower_ext;
    logic signed [PRW-1:0]         lim_pos;
    logic signed [PRW-1:0]         pwm_clamp;
    logic signed [PRW-1:0]         pwm_abs;
    logic                          out_free;
    logic                          target_zero;

    assign out_free    = !result_valid_reg || !result_stall;
    assign target_zero = (target_reg == 16'sd0);

    always_comb
    begin
        unique case (ctrl.mul_sel)
            MUL_SPEED:
            begin
                mul_a = AW'(count_reg);
                mul_b = $signed({1'b0, cfg.speed_scale});
            end
            MUL_PROP:
            begin
                mul_a = AW'(err_reg);
                mul_b = $signed({1'b0, cfg.prop_gain});
            end
            MUL_INTEG:
            begin
                mul_a = AW'(integ_reg);
                mul_b = $signed({1'b0, cfg.integ_gain});
            end
            default:
            begin
                mul_a = AW'(count_reg);
                mul_b = $signed({1'b0, cfg.speed_scale});
            end
        endcase
        prod_next = ctrl.prod_en ? (mul_a * mul_b) : prod_reg;

        spd_round = prod_reg + (prod_reg[PRW-1] ? SPD_BIAS : '0);
        out_round = acc_reg + (acc_reg[PRW-1] ? OUT_BIAS : '0);
        unique case (ctrl.acc_op)
            ACC_HOLD:      acc_next = acc_reg;
            ACC_LOAD_SPD:  acc_next = spd_round >>> SPD_SH;
            ACC_LOAD_PROD: acc_next = prod_reg;
            ACC_ADD_PROD:  acc_next = acc_reg + prod_reg;
            ACC_TRUNC_OUT: acc_next = out_round >>> OUT_SH;
            default:       acc_next = acc_reg;
        endcase

        spd_val    = cfg.count_negate ? -acc_reg : acc_reg;
        speed_next = speed_reg;
        count_next = count_reg;
        integ_next = integ_reg;
        if (ctrl.speed_en)
        begin
            priority if (spd_val > SPD_MAX)
                speed_next = 16'sh7fff;
            else if (spd_val < SPD_MIN)
                speed_next = -16'sh8000;
            else
                speed_next = spd_val[15:0];
            count_next = '0;
            if (target_zero || restart_reg)
            begin
                integ_next = '0;
            end
        end

        if (ctrl.edge_en)
        begin
            if (!phase_b_reg && (count_reg != CMAX))
            begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end
            else if (phase_b_reg && (count_reg != CMIN))
            begin
                count_next = count_reg - COUNT_WIDTH'(1);
            end
        end

        err_next  = ctrl.err_en ? (17'(target_reg) - 17'(speed_reg)) : err_reg;

        sum_raw   = 18'(integ_reg) + 18'(err_reg);
        upper_ext = $signed({3'b000, cfg.integ_upper});
        lower_ext = 18'($signed(cfg.integ_lower));
        if (ctrl.sum_en)
        begin
            priority if (sum_raw > upper_ext)
                integ_next = upper_ext[15:0];
            else if (sum_raw < lower_ext)
                integ_next = lower_ext[15:0];
            else
                integ_next = sum_raw[15:0];
        end

        lim_pos = $signed(PRW'(cfg.duty_limit));
        priority if (acc_reg > lim_pos)
            pwm_clamp = lim_pos;
        else if (acc_reg < -lim_pos)
            pwm_clamp = -lim_pos;
        else
            pwm_clamp = acc_reg;
        pwm_abs = pwm_clamp[PRW-1] ? -pwm_clamp : pwm_clamp;

        result_valid_next = result_valid_reg && result_stall;
        dir_next          = dir_reg;
        duty_next         = duty_reg;
        mspeed_next       = mspeed_reg;
        if ((ctrl.emit != EMIT_NONE) && out_free)
        begin
            result_valid_next = 1'b1;
            mspeed_next       = speed_reg;
            if (ctrl.emit == EMIT_STOP)
            begin
                dir_next  = DIR_STOP;
                duty_next = '0;
            end
            else
            begin
                priority if (pwm_clamp > 0)
                    dir_next = DIR_FWD;
                else if (pwm_clamp < 0)
                    dir_next = DIR_REV;
                else
                    dir_next = DIR_STOP;
                duty_next = pwm_abs[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            integ_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            integ_reg        <= integ_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            phase_b_reg <= phase_b;
            target_reg  <= setpoint;
            restart_reg <= restart;
        end
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        speed_reg  <= speed_next;
        err_reg    <= err_next;
        dir_reg    <= dir_next;
        duty_reg   <= duty_next;
        mspeed_reg <= mspeed_next;
    end

    assign status.target_zero = target_zero;
    assign status.out_free    = out_free;
    assign result_valid       = result_valid_reg;
    assign drive_dir          = dir_reg;
    assign duty               = duty_reg;
    assign measured_speed     = mspeed_reg;

endmodule
